// ===== hw/rtl/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg: text console cursor engine package
// Shared widths, defaults, command and register codes, state encoding.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // default screen geometry
    localparam int DEF_ROWS    = 25;
    localparam int DEF_COLUMNS = 80;

    // item field widths
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int CELL_W     = 16;
    localparam int COLOR_W    = 8;
    localparam int PROT_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // address unit operand widths, cover the largest allowed geometry
    localparam int UNIT_ROW_W = 7;
    localparam int UNIT_COL_W = 8;
    localparam int UNIT_W     = 16;

    // characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    // register reset values
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;
    localparam logic [PROT_W-1:0]  PROT_RESET  = 5'd5;

    // commands
    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_READ      = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEXT_COLOR    = 1'b0,
        REG_PROTECTED_ROW = 1'b1
    } t_reg;

    // sequencer states
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_RDWAIT = 9'b000000010,
        S_BS_RD  = 9'b000000100,
        S_BS_CHK = 9'b000001000,
        S_BS_WR  = 9'b000010000,
        S_SCROLL = 9'b000100000,
        S_BLANK  = 9'b001000000,
        S_CLEAR  = 9'b010000000,
        S_FIN    = 9'b100000000
    } t_state;

endpackage

// ===== hw/rtl/tcce_channels.sv =====
// ----------------------------------------------------------------------------
// tcce channels: valid/ready interfaces of the console engine
// Command, result and configuration write channels.
// ----------------------------------------------------------------------------

// command item channel
interface tcce_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [tcce_pkg::OP_W-1:0]          op;
    logic [tcce_pkg::CHAR_W-1:0]        char_code;
    logic [tcce_pkg::ROW_OUT_W-1:0]     read_row;
    logic [tcce_pkg::COL_OUT_W-1:0]     read_column;

    modport source (output valid, op, char_code, read_row, read_column, input ready);
    modport sink   (input valid, op, char_code, read_row, read_column, output ready);
endinterface

// result item channel
interface tcce_res_if;
    logic                               valid;
    logic                               ready;
    logic [tcce_pkg::ROW_OUT_W-1:0]     cursor_row_out;
    logic [tcce_pkg::COL_OUT_W-1:0]     cursor_column_out;
    logic [tcce_pkg::CELL_W-1:0]        cell_value;
    logic                               scrolled;

    modport source (output valid, cursor_row_out, cursor_column_out, cell_value, scrolled,
                    input ready);
    modport sink   (input valid, cursor_row_out, cursor_column_out, cell_value, scrolled,
                    output ready);
endinterface

// configuration write channel
interface tcce_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tcce_pkg::CFG_IDX_W-1:0]     index;
    logic [tcce_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/tcce_ram.sv =====
// ----------------------------------------------------------------------------
// tcce_ram: screen cell store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcce_ram #(
    parameter int DEPTH  = tcce_pkg::DEF_ROWS * tcce_pkg::DEF_COLUMNS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [tcce_pkg::CELL_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [tcce_pkg::CELL_W-1:0] o_rdata
);

    logic [tcce_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tcce_pkg::CELL_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/text_console_cursor_engine.sv =====
// Reads wait on the registered store read; backspace from column 0 skips trailing spaces.
// Scroll copies the rows up and blanks the last row; clear blanks every cell, one cell a cycle.
// Throughput: one item at a time; the next item is taken once the result is staged.
// Cycle count is set by the one-write, one-read cell store and the shared address multiply-add.
// Reset: synchronous active low; cursor at 0,0, text_color 7, protected_row 5.
// The cell store is not cleared by reset; cells read before written are undefined.
// ----------------------------------------------------------------------------
// text_console_cursor_engine: character-cell console with cursor
// Sequencer around one cell store and one row*COLUMNS+column address unit.
// ----------------------------------------------------------------------------
module text_console_cursor_engine #(
    parameter int ROWS    = tcce_pkg::DEF_ROWS,
    parameter int COLUMNS = tcce_pkg::DEF_COLUMNS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tcce_cmd_if.sink        i_cmd,
    tcce_res_if.source      o_res,
    tcce_cfg_if.sink        i_cfg
);

    localparam int TOTAL  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int RW     = $clog2(ROWS);
    localparam int CW     = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(TOTAL - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
    localparam logic [RW-1:0]     ROW_LAST  = RW'(ROWS - 1);
    localparam logic [CW-1:0]     COL_LAST  = CW'(COLUMNS - 1);

    tcce_pkg::t_state r_state, n_state;

    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_col, n_col;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [ADDR_W-1:0] r_waddr, n_waddr;
    logic              r_wv, n_wv;
    logic [tcce_pkg::CELL_W-1:0] r_cell, n_cell;
    logic              r_scr, n_scr;

    logic [tcce_pkg::COLOR_W-1:0] r_color;
    logic [tcce_pkg::PROT_W-1:0]  r_prot;

    // staged result
    logic                           r_ov;
    logic [tcce_pkg::ROW_OUT_W-1:0] r_o_row;
    logic [tcce_pkg::COL_OUT_W-1:0] r_o_col;
    logic [tcce_pkg::CELL_W-1:0]    r_o_cell;
    logic                           r_o_scr;

    logic cmd_acc;
    logic fin_load;
    logic rd_in_range;
    tcce_pkg::t_op op;

    // shared address unit
    logic [tcce_pkg::UNIT_ROW_W-1:0] u_row;
    logic [tcce_pkg::UNIT_COL_W-1:0] u_col;
    logic [tcce_pkg::UNIT_W-1:0]     u_sum;
    logic [ADDR_W-1:0]               unit_addr;

    // cell store ports
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [tcce_pkg::CELL_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [ADDR_W-1:0]           mem_raddr;
    logic [tcce_pkg::CELL_W-1:0] mem_q;
    logic [tcce_pkg::CELL_W-1:0] blank;

    assign op          = tcce_pkg::t_op'(i_cmd.op);
    assign i_cmd.ready = (r_state == tcce_pkg::S_IDLE);
    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign i_cfg.ready = 1'b1;
    assign blank       = {r_color, tcce_pkg::CH_SPACE};
    assign fin_load    = (r_state == tcce_pkg::S_FIN) && (!r_ov || o_res.ready);

    assign rd_in_range = (8'(i_cmd.read_row) < 8'(ROWS)) &&
                         (9'(i_cmd.read_column) < 9'(COLUMNS));

    // operand select: read command addresses the requested cell, else the cursor
    always_comb begin
        if (r_state == tcce_pkg::S_IDLE && op == tcce_pkg::OP_READ) begin
            u_row = tcce_pkg::UNIT_ROW_W'(i_cmd.read_row);
            u_col = tcce_pkg::UNIT_COL_W'(i_cmd.read_column);
        end else begin
            u_row = tcce_pkg::UNIT_ROW_W'(r_row);
            u_col = tcce_pkg::UNIT_COL_W'(r_col);
        end
    end

    assign u_sum     = tcce_pkg::UNIT_W'(u_row) * tcce_pkg::UNIT_W'(COLUMNS)
                     + tcce_pkg::UNIT_W'(u_col);
    assign unit_addr = u_sum[ADDR_W-1:0];

    tcce_ram #(
        .DEPTH  (TOTAL),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_addr    = r_addr;
        n_waddr   = r_waddr;
        n_wv      = r_wv;
        n_cell    = r_cell;
        n_scr     = r_scr;
        mem_we    = 1'b0;
        mem_waddr = unit_addr;
        mem_wdata = blank;
        mem_re    = 1'b0;
        mem_raddr = unit_addr;

        case (r_state)
            tcce_pkg::S_IDLE: begin
                if (cmd_acc) begin
                    n_cell = '0;
                    n_scr  = 1'b0;
                    case (op)
                        tcce_pkg::OP_WRITE: begin
                            if (i_cmd.char_code != tcce_pkg::CH_NEWLINE) begin
                                mem_we    = 1'b1;
                                mem_wdata = {r_color, i_cmd.char_code};
                            end
                            if (i_cmd.char_code == tcce_pkg::CH_NEWLINE || r_col == COL_LAST)
                            begin
                                // next row, scrolling past the bottom
                                n_col = '0;
                                if (r_row == ROW_LAST) begin
                                    n_scr   = 1'b1;
                                    n_addr  = '0;
                                    n_wv    = 1'b0;
                                    n_state = tcce_pkg::S_SCROLL;
                                end else begin
                                    n_row   = r_row + 1'b1;
                                    n_state = tcce_pkg::S_FIN;
                                end
                            end else begin
                                n_col   = r_col + 1'b1;
                                n_state = tcce_pkg::S_FIN;
                            end
                        end
                        tcce_pkg::OP_BACKSPACE: begin
                            if (r_col != '0) begin
                                n_col   = r_col - 1'b1;
                                n_state = tcce_pkg::S_BS_WR;
                            end else if (r_row == '0 || 8'(r_row) == 8'(r_prot)) begin
                                n_state = tcce_pkg::S_FIN;
                            end else begin
                                n_row   = r_row - 1'b1;
                                n_col   = COL_LAST;
                                n_state = tcce_pkg::S_BS_RD;
                            end
                        end
                        tcce_pkg::OP_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_addr  = '0;
                            n_state = tcce_pkg::S_CLEAR;
                        end
                        tcce_pkg::OP_READ: begin
                            if (rd_in_range) begin
                                mem_re  = 1'b1;
                                n_state = tcce_pkg::S_RDWAIT;
                            end else begin
                                n_state = tcce_pkg::S_FIN;
                            end
                        end
                        default: begin
                            n_state = tcce_pkg::S_FIN;
                        end
                    endcase
                end
            end
            tcce_pkg::S_RDWAIT: begin
                n_cell  = mem_q;
                n_state = tcce_pkg::S_FIN;
            end
            // skip trailing spaces on the previous row
            tcce_pkg::S_BS_RD: begin
                mem_re  = 1'b1;
                n_state = tcce_pkg::S_BS_CHK;
            end
            tcce_pkg::S_BS_CHK: begin
                if (mem_q[tcce_pkg::CHAR_W-1:0] == tcce_pkg::CH_SPACE && r_col != '0) begin
                    n_col   = r_col - 1'b1;
                    n_state = tcce_pkg::S_BS_RD;
                end else begin
                    n_state = tcce_pkg::S_BS_WR;
                end
            end
            tcce_pkg::S_BS_WR: begin
                mem_we  = 1'b1;
                n_state = tcce_pkg::S_FIN;
            end
            // copy each cell one row up, the read of each cell running ahead of its write
            tcce_pkg::S_SCROLL: begin
                if (r_wv) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_waddr;
                    mem_wdata = mem_q;
                end
                if (r_addr != LAST_BASE) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_addr + ROW_STEP;
                    n_waddr   = r_addr;
                    n_wv      = 1'b1;
                    n_addr    = r_addr + 1'b1;
                end else begin
                    n_wv    = 1'b0;
                    n_state = tcce_pkg::S_BLANK;
                end
            end
            tcce_pkg::S_BLANK, tcce_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_addr;
                if (r_addr == ADDR_LAST) begin
                    n_state = tcce_pkg::S_FIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            tcce_pkg::S_FIN: begin
                if (fin_load) begin
                    n_state = tcce_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tcce_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcce_pkg::S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_wv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_wv    <= n_wv;
        end
    end

    // sweep counters and item payload
    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_waddr <= n_waddr;
        r_cell  <= n_cell;
        r_scr   <= n_scr;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= tcce_pkg::COLOR_RESET;
            r_prot  <= tcce_pkg::PROT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (tcce_pkg::t_reg'(i_cfg.index))
                tcce_pkg::REG_TEXT_COLOR:    r_color <= i_cfg.data;
                tcce_pkg::REG_PROTECTED_ROW: r_prot  <= i_cfg.data[tcce_pkg::PROT_W-1:0];
                default: begin
                    r_color <= r_color;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (fin_load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            r_o_row  <= tcce_pkg::ROW_OUT_W'(r_row);
            r_o_col  <= tcce_pkg::COL_OUT_W'(r_col);
            r_o_cell <= r_cell;
            r_o_scr  <= r_scr;
        end
    end

    assign o_res.valid             = r_ov;
    assign o_res.cursor_row_out    = r_o_row;
    assign o_res.cursor_column_out = r_o_col;
    assign o_res.cell_value        = r_o_cell;
    assign o_res.scrolled          = r_o_scr;

    // checks
    a_clear_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd_acc && op == tcce_pkg::OP_CLEAR) |=> (r_state == tcce_pkg::S_CLEAR))
        else $error("clear item did not start the clearing sweep");

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= ROW_LAST) && (r_col <= COL_LAST))
        else $error("cursor outside the screen");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcce_pkg::S_IDLE && !cmd_acc) |-> !mem_we)
        else $error("cell store written with no item in progress");

    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_load && r_scr |=> (r_o_col == '0) && (r_o_row == tcce_pkg::ROW_OUT_W'(ROW_LAST)))
        else $error("scrolled result not at start of the last row");

endmodule

// ===== tb/sv/tcce_console_checker.sv =====
// ----------------------------------------------------------------------------
// tcce_console_checker: result checker for the text console cursor engine
// Watches the command, result and register write channels, keeps a shadow
// screen, cursor and register set, predicts one result per accepted command
// item and compares each result item field by field with the oldest one.
// ----------------------------------------------------------------------------
module tcce_console_checker
    import tcce_pkg::*;
#(
    parameter int ROWS    = DEF_ROWS,
    parameter int COLUMNS = DEF_COLUMNS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tcce_cmd_if  i_cmd,
    tcce_res_if  i_res,
    tcce_cfg_if  i_cfg,
    output int   o_errors,
    output int   o_outstanding
);

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic [CELL_W-1:0]    cell_val;
        logic                 scrolled;
    } t_console_result;

    // shadow of the screen, cursor and registers
    logic [CELL_W-1:0]  shadow_cells [ROWS*COLUMNS];
    int                 shadow_row;
    int                 shadow_col;
    logic [COLOR_W-1:0] shadow_color;
    logic [PROT_W-1:0]  shadow_prot;

    t_console_result    pending_results [$];
    t_console_result    oldest;
    int                 error_count = 0;

    initial begin
        foreach (shadow_cells[i]) shadow_cells[i] = '0;
    end

    // cursor to the start of the next row, scrolling off the bottom
    function automatic logic next_line();
        logic [CELL_W-1:0] blank;
        blank      = {shadow_color, CH_SPACE};
        shadow_col = 0;
        shadow_row++;
        if (shadow_row < ROWS) return 1'b0;
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
            shadow_cells[i] = shadow_cells[i + COLUMNS];
        for (int i = 0; i < COLUMNS; i++)
            shadow_cells[(ROWS - 1) * COLUMNS + i] = blank;
        shadow_row = ROWS - 1;
        return 1'b1;
    endfunction

    // apply one command item to the shadow state and form its result
    function automatic t_console_result predict_console_step(
        t_op                  op,
        logic [CHAR_W-1:0]    ch,
        logic [ROW_OUT_W-1:0] rr,
        logic [COL_OUT_W-1:0] rc
    );
        t_console_result   r;
        logic [CELL_W-1:0] blank;
        r     = '0;
        blank = {shadow_color, CH_SPACE};
        case (op)
            OP_WRITE: begin
                if (ch == CH_NEWLINE) begin
                    r.scrolled = next_line();
                end else begin
                    shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_color, ch};
                    shadow_col++;
                    if (shadow_col >= COLUMNS) r.scrolled = next_line();
                end
            end
            OP_BACKSPACE: begin
                // column zero of row zero or of the protected row holds the cursor
                if (!(shadow_col == 0 &&
                      (shadow_row == int'(shadow_prot) || shadow_row == 0))) begin
                    if (shadow_col == 0) begin
                        // back to the previous row, over its trailing spaces
                        shadow_row--;
                        shadow_col = COLUMNS - 1;
                        while (shadow_col > 0 &&
                               shadow_cells[shadow_row * COLUMNS + shadow_col][CHAR_W-1:0]
                               == CH_SPACE)
                            shadow_col--;
                    end else begin
                        shadow_col--;
                    end
                    shadow_cells[shadow_row * COLUMNS + shadow_col] = blank;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < ROWS * COLUMNS; i++) shadow_cells[i] = blank;
                shadow_row = 0;
                shadow_col = 0;
            end
            default: begin
                // reads outside the screen answer zero
                if (rr < ROWS && rc < COLUMNS) r.cell_val = shadow_cells[rr * COLUMNS + rc];
            end
        endcase
        r.row = shadow_row[ROW_OUT_W-1:0];
        r.col = shadow_col[COL_OUT_W-1:0];
        return r;
    endfunction

    // observe all three channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_row   = 0;
            shadow_col   = 0;
            shadow_color = COLOR_RESET;
            shadow_prot  = PROT_RESET;
            pending_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result item with no command waiting: row %0d column %0d",
                           i_res.cursor_row_out, i_res.cursor_column_out);
                    error_count++;
                end else begin
                    oldest = pending_results.pop_front();
                    if (oldest.row !== i_res.cursor_row_out) begin
                        $error("cursor_row_out: expected %0d, actual %0d",
                               oldest.row, i_res.cursor_row_out);
                        error_count++;
                    end
                    if (oldest.col !== i_res.cursor_column_out) begin
                        $error("cursor_column_out: expected %0d, actual %0d",
                               oldest.col, i_res.cursor_column_out);
                        error_count++;
                    end
                    if (oldest.cell_val !== i_res.cell_value) begin
                        $error("cell_value: expected 0x%04h, actual 0x%04h",
                               oldest.cell_val, i_res.cell_value);
                        error_count++;
                    end
                    if (oldest.scrolled !== i_res.scrolled) begin
                        $error("scrolled: expected %0b, actual %0b",
                               oldest.scrolled, i_res.scrolled);
                        error_count++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg'(i_cfg.index))
                    REG_TEXT_COLOR:    shadow_color = i_cfg.data[COLOR_W-1:0];
                    REG_PROTECTED_ROW: shadow_prot  = i_cfg.data[PROT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.valid && i_cmd.ready)
                pending_results.push_back(predict_console_step(t_op'(i_cmd.op),
                    i_cmd.char_code, i_cmd.read_row, i_cmd.read_column));
        end
        o_outstanding <= pending_results.size();
        o_errors      <= error_count;
    end

endmodule

// ===== tb/sv/text_console_cursor_engine_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine_tb: top of the console engine testbench
// Resets the engine, then runs a directed opening and several register
// settings of random console traffic (text runs, newlines, backspace bursts,
// reads, clears and noise) with random idling on both sides. The checker
// beside the engine predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_tb;
    import tcce_pkg::*;

    localparam int ROWS         = DEF_ROWS;
    localparam int COLUMNS      = DEF_COLUMNS;
    localparam int IDLE_PCT     = 27;
    localparam int QUIET_LIMIT  = 8 * (ROWS * COLUMNS + 100);
    localparam int SETTLE_CYC   = 8;
    localparam int DRAIN_CYC    = ROWS * COLUMNS + 16;
    localparam int PHASE_ITEMS  = 160;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic full_speed;
    int   err_count;
    int   pending;
    int   quiet_cycles = 0;
    int   items_sent   = 0;
    int   reg_writes   = 0;
    int   settings     = 1;

    tcce_cmd_if cmd_ch ();
    tcce_res_if res_ch ();
    tcce_cfg_if cfg_ch ();

    text_console_cursor_engine #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    tcce_console_checker #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_ch),
        .i_res         (res_ch),
        .i_cfg         (cfg_ch),
        .o_errors      (err_count),
        .o_outstanding (pending)
    );

    always #6 i_clk = ~i_clk;

    // result side back-pressure
    always @(posedge i_clk) begin
        res_ch.ready <= full_speed || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog on cycles with no item moving on any channel
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("text_console_cursor_engine_tb: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one command item, with random idle cycles ahead of it
    task automatic send_cmd(input t_op op, input logic [CHAR_W-1:0] ch,
                            input logic [ROW_OUT_W-1:0] rr,
                            input logic [COL_OUT_W-1:0] rc);
        while (!full_speed && $urandom_range(99) < IDLE_PCT) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.op          <= op;
        cmd_ch.char_code   <= ch;
        cmd_ch.read_row    <= rr;
        cmd_ch.read_column <= rc;
        do @(posedge i_clk); while (!cmd_ch.ready);
        items_sent++;
    endtask

    // unused fields carry random bits
    task automatic send_op(input t_op op, input logic [CHAR_W-1:0] ch);
        send_cmd(op, ch, ROW_OUT_W'($urandom), COL_OUT_W'($urandom));
    endtask

    task automatic send_read(input int rr, input int rc);
        send_cmd(OP_READ, CHAR_W'($urandom), ROW_OUT_W'(rr), COL_OUT_W'(rc));
    endtask

    task automatic write_reg(input t_reg idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        reg_writes++;
        @(posedge i_clk);
    endtask

    // let every result come back, then load a new register setting
    task automatic configure(input logic [COLOR_W-1:0] color,
                             input logic [PROT_W-1:0] prot);
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if ($urandom_range(1)) begin
            write_reg(REG_TEXT_COLOR, color);
            write_reg(REG_PROTECTED_ROW, CFG_DATA_W'(prot));
        end else begin
            write_reg(REG_PROTECTED_ROW, CFG_DATA_W'(prot));
            write_reg(REG_TEXT_COLOR, color);
        end
        settings++;
    endtask

    function automatic logic [CHAR_W-1:0] pick_char();
        int r;
        r = $urandom_range(99);
        if (r < 20) return CH_SPACE;
        if (r < 30) return CHAR_W'($urandom_range(255));
        return CHAR_W'($urandom_range(126, 33));
    endfunction

    // random console traffic in bursts that look like real text editing
    task automatic run_random(input int count);
        int start;
        int kind;
        int burst;
        start = items_sent;
        while (items_sent - start < count) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                // text run, now and then long enough to wrap
                burst = ($urandom_range(19) == 0) ? $urandom_range(90, 60)
                                                   : $urandom_range(12, 1);
                repeat (burst) send_op(OP_WRITE, pick_char());
                if ($urandom_range(99) < 70) send_op(OP_WRITE, CH_NEWLINE);
            end else if (kind < 58) begin
                repeat ($urandom_range(3, 1)) send_op(OP_WRITE, CH_NEWLINE);
            end else if (kind < 77) begin
                repeat ($urandom_range(6, 1)) send_op(OP_BACKSPACE, CHAR_W'($urandom));
            end else if (kind < 94) begin
                if ($urandom_range(9) == 0)
                    send_read($urandom_range(31), $urandom_range(127));
                else
                    send_read($urandom_range(ROWS - 1), $urandom_range(COLUMNS - 1));
            end else if (kind < 99) begin
                // noise item with every field random
                send_cmd(t_op'($urandom_range(3)), CHAR_W'($urandom),
                         ROW_OUT_W'($urandom), COL_OUT_W'($urandom));
            end else begin
                send_op(OP_CLEAR, CHAR_W'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        full_speed         = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.op          = OP_WRITE;
        cmd_ch.char_code   = '0;
        cmd_ch.read_row    = '0;
        cmd_ch.read_column = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_TEXT_COLOR;
        cfg_ch.data        = '0;
        res_ch.ready       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // opening under reset register values, screen cleared before any read
        send_op(OP_CLEAR, 8'h00);
        send_read(0, 0);
        send_op(OP_BACKSPACE, 8'h00);
        send_op(OP_WRITE, 8'h41);
        send_op(OP_WRITE, 8'hFF);
        send_op(OP_WRITE, 8'h00);
        send_op(OP_WRITE, CH_SPACE);
        send_read(0, 1);
        send_read(31, 127);
        send_read(ROWS, 0);
        send_read(0, COLUMNS);
        // backspace from column zero skips the trailing spaces of row zero
        send_op(OP_WRITE, CH_NEWLINE);
        send_op(OP_BACKSPACE, 8'hFF);
        send_read(0, 2);
        // column zero of the protected row holds the cursor
        repeat (5) send_op(OP_WRITE, CH_NEWLINE);
        send_op(OP_BACKSPACE, 8'h00);
        run_random(PHASE_ITEMS - 20);

        configure(8'h00, 5'd0);
        run_random(PHASE_ITEMS);

        // no idling on either side through this setting
        configure(8'hFF, 5'd24);
        full_speed <= 1'b1;
        run_random(PHASE_ITEMS);
        cmd_ch.valid <= 1'b0;
        full_speed   <= 1'b0;
        @(posedge i_clk);

        configure(COLOR_W'($urandom), 5'd31);
        run_random(PHASE_ITEMS);
        configure(COLOR_W'($urandom), PROT_W'($urandom_range(ROWS - 1)));
        run_random(PHASE_ITEMS);
        configure(COLOR_W'($urandom), PROT_W'($urandom_range(ROWS - 1)));
        run_random(PHASE_ITEMS);

        // drain
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("%0d command items and %0d register writes over %0d register settings",
                 items_sent, reg_writes, settings);
        $display("traffic: text runs with wraps, newlines into scrolls, backspace bursts, reads");
        if (err_count == 0 && pending == 0) begin
            $display("text_console_cursor_engine_tb: done, clean");
        end else begin
            $display("text_console_cursor_engine_tb: done, errors");
        end
        $finish;
    end

endmodule
